### sv/bmh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared types and codes for the binary min-heap engine.
// ----------------------------------------------------------------------------
package bmh_pkg;

  // heap size and key width; index and count widths follow from the size
  localparam int CAPACITY = 1024;
  localparam int KEY_W = 32;

  localparam int ACT_W = 2;
  localparam int POS_W = $clog2(CAPACITY);
  localparam int STAT_W = 3;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 2'd0,
    ACT_EXTRACT = 2'd1,
    ACT_DECR    = 2'd2,
    ACT_DELETE  = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_BADIDX     = 3'd3,
    ST_NOTSMALLER = 3'd4
  } status_t;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [KEY_W-1:0] key_value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [KEY_W-1:0] removed_key;
    logic [CNT_W-1:0]        entry_count;
    logic signed [KEY_W-1:0] min_key;
    logic                    min_valid;
  } out_item_t;

endpackage : bmh_pkg
`default_nettype wire

### sv/binary_min_heap_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_min_heap_engine_unit
// Binary min-heap priority queue of signed keys held in a single RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_data and raise in_push while in_full is low; a
//   beat is one command (insert, extract minimum, decrease key, delete).
//   Commands enter a two-entry queue, so a beat is taken while the sequencer
//   is busy and while a result waits.
//   Result channel: while out_empty is low, out_data holds the oldest
//   result; raise out_pop to take it. Exactly one result per command.
//   A command flagged on entry goes straight to the result; a decrease whose
//   key is not smaller ends after one read of its entry; an insert reads and
//   compares its parent; a sift walks level by level, up by reading the
//   parent, down by reading both children. The sequencer handles one command
//   at a time and takes the next only after the last result is loaded; the
//   one RAM read per step sets the pace.
//   Reset empties the heap and both queues; RAM contents need no clearing.
//   A stalled receiver holds the finished result; the sequencer then waits
//   and the command queue fills until in_full rises.
// ----------------------------------------------------------------------------
module binary_min_heap_engine_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire bmh_pkg::in_item_t  in_data,
  output logic                    in_full,
  input  wire logic               out_pop,
  output bmh_pkg::out_item_t      out_data,
  output logic                    out_empty
);
  import bmh_pkg::*;

  in_item_t  q_data;
  logic      q_empty, q_take, res_valid;

  bmh_cmd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(in_push), .push_data(in_data), .full(in_full),
    .pop(q_take), .pop_data(q_data), .empty(q_empty)
  );

  bmh_core u_core (
    .clk(clk), .rst_n(rst_n), .cmd_valid(!q_empty), .cmd(q_data), .cmd_take(q_take),
    .res(out_data), .res_valid(res_valid), .res_take(out_pop)
  );

  assign out_empty = !res_valid;

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed");
  a_take_gated: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> !q_empty) else $error("command taken from empty queue");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty) else $error("result after reset");

endmodule : binary_min_heap_engine_unit
`default_nettype wire

### sv/bmh_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : bmh_ram
`default_nettype wire

### sv/bmh_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmh_cmd_fifo
// Two-entry command queue between the front end and the heap sequencer.
// ----------------------------------------------------------------------------
module bmh_cmd_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire bmh_pkg::in_item_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output bmh_pkg::in_item_t      pop_data,
  output logic                   empty
);
  import bmh_pkg::*;

  in_item_t   slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] fill_r;

  assign full     = (fill_r == 2'd2);
  assign empty    = (fill_r == 2'd0);
  assign pop_data = slot_r[rptr_r];

  // store beats and advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push && !full) begin
        slot_r[wptr_r] <= push_data;
        wptr_r <= ~wptr_r;
      end
      if (pop && !empty) begin
        rptr_r <= ~rptr_r;
      end
      fill_r <= fill_r + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3) else $error("queue fill out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> full) else $error("full queue lost an entry");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> wptr_r == rptr_r) else $error("pointers differ when empty");

endmodule : bmh_cmd_fifo
`default_nettype wire

### sv/bmh_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmh_core
// Heap sequencer: validates one command, walks the sift over the RAM and
// holds the finished result in a one-entry output register.
// ----------------------------------------------------------------------------
module bmh_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  input  wire bmh_pkg::in_item_t  cmd,
  output logic                    cmd_take,
  output bmh_pkg::out_item_t      res,
  output logic                    res_valid,
  input  wire logic               res_take
);
  import bmh_pkg::*;

  localparam int AW = POS_W;
  localparam int CW = CNT_W;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD_LAST, S_FIX, S_UP_RD, S_UP_CMP,
    S_DN_RDL, S_DN_RDR, S_DN_CMP, S_ROOT, S_DONE
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   cnt_r;
  logic [AW-1:0]   idx_r;
  key_t            cur_r, lch_r;
  logic            lok_r;
  logic [ACT_W-1:0] act_r;
  key_t            ckey_r;
  logic [POS_W-1:0] cpos_r;
  logic [STAT_W-1:0] stat_r;
  key_t            rem_r;
  logic            out_v_r;
  out_item_t       out_r;
  logic            res_load;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  key_t            wdata, rdata;

  bmh_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // child indexes, widened to compare against the count
  logic [CW:0] lidx, ridx, pos_ext;
  logic [AW-1:0] parent;
  assign lidx    = (CW+1)'({idx_r, 1'b1});
  assign ridx    = (CW+1)'({idx_r, 1'b0}) + (CW+1)'(2);
  assign parent  = (idx_r - AW'(1)) >> 1;
  assign pos_ext = (CW+1)'(cpos_r);

  assign cmd_take  = (state_r == S_IDLE) && cmd_valid;
  assign res_valid = out_v_r;
  assign res       = out_r;
  assign res_load  = (state_r == S_DONE) && (!out_v_r || res_take);

  // combinational RAM control, driven by state
  always_comb begin
    we = 1'b0; waddr = idx_r; wdata = cur_r; raddr = idx_r;
    unique case (state_r)
      S_CHECK:   raddr = (act_r == ACT_EXTRACT) ? '0 : AW'(cpos_r);
      S_RD_LAST: raddr = AW'(cnt_r);
      S_UP_RD:   raddr = parent;
      S_DN_RDL:  raddr = AW'(lidx);
      S_DN_RDR:  raddr = AW'(ridx);
      S_ROOT, S_DONE: raddr = '0;
      default:   raddr = idx_r;
    endcase
    // place the moved last entry, pull a larger parent down, or settle the key
    if (state_r == S_UP_CMP) begin
      we = 1'b1;
      wdata = (lok_r || (rdata > cur_r && idx_r != '0)) ? rdata : cur_r;
    end
    // park the key in the hole before looking at its children
    if (state_r == S_DN_RDL) begin
      we = 1'b1;
    end
    if (state_r == S_DN_CMP) begin
      we = 1'b1; waddr = idx_r; wdata = cur_r;
      if (lok_r && cur_r > lch_r) begin wdata = lch_r; end
      if (ridx < (CW+1)'(cnt_r) && rdata < ((lok_r && cur_r > lch_r) ? lch_r : cur_r)) begin
        wdata = rdata;
      end
    end
  end

  // sequencer state, result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
      lok_r   <= 1'b0;
    end else begin
      // load a finished result or drop the taken one
      if (res_load) begin
        out_v_r <= 1'b1;
      end else if (res_take && out_v_r) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (cmd_valid) begin
          act_r  <= cmd.action;
          ckey_r <= key_t'(cmd.key_value);
          cpos_r <= cmd.position;
          stat_r <= ST_OK;
          rem_r  <= '0;
          lok_r  <= 1'b0;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          // rdata valid next state (read of position, or of the root)
          unique case (act_r)
            ACT_INSERT: if (cnt_r == CW'(CAPACITY)) begin
              stat_r <= ST_FULL; state_r <= S_ROOT;
            end else begin
              idx_r <= AW'(cnt_r); cur_r <= ckey_r;
              cnt_r <= cnt_r + CW'(1); state_r <= S_UP_RD;
            end
            ACT_EXTRACT: if (cnt_r == '0) begin
              stat_r <= ST_EMPTY; state_r <= S_ROOT;
            end else begin
              cpos_r <= '0; idx_r <= '0; state_r <= S_FIX;
            end
            ACT_DECR: if (pos_ext >= (CW+1)'(cnt_r)) begin
              stat_r <= ST_BADIDX; state_r <= S_ROOT;
            end else begin
              idx_r <= AW'(cpos_r); state_r <= S_FIX;
            end
            default: if (cnt_r == '0) begin
              stat_r <= ST_EMPTY; state_r <= S_ROOT;
            end else if (pos_ext >= (CW+1)'(cnt_r)) begin
              stat_r <= ST_BADIDX; state_r <= S_ROOT;
            end else begin
              idx_r <= AW'(cpos_r); state_r <= S_FIX;
            end
          endcase
        end
        S_FIX: begin
          // rdata holds the entry at idx_r (read issued in S_CHECK)
          if (act_r == ACT_DECR) begin
            if (ckey_r > rdata) begin
              stat_r <= ST_NOTSMALLER; state_r <= S_ROOT;
            end else begin
              cur_r <= ckey_r; state_r <= S_UP_RD;
            end
          end else begin
            rem_r <= rdata;
            cnt_r <= cnt_r - CW'(1);
            state_r <= S_RD_LAST;
          end
        end
        S_RD_LAST: begin
          // read of entry cnt_r issued; next cycle decide direction
          state_r <= S_UP_CMP;
          lok_r   <= 1'b1;
          if (cnt_r == CW'(idx_r)) begin
            state_r <= S_ROOT;
          end
        end
        S_UP_RD: state_r <= S_UP_CMP;
        S_UP_CMP: begin
          if (lok_r) begin
            // first look after removal: rdata is the moved last entry
            lok_r <= 1'b0;
            cur_r <= rdata;
            if (idx_r != '0) begin
              state_r <= S_UP_RD;
            end else begin
              state_r <= S_DN_RDL;
            end
          end else if (rdata > cur_r && idx_r != '0) begin
            idx_r <= parent; state_r <= S_UP_RD;
          end else if (act_r[0] && idx_r == AW'(cpos_r) && (act_r != ACT_INSERT)) begin
            state_r <= S_DN_RDL;
          end else begin
            state_r <= S_ROOT;
          end
        end
        S_DN_RDL: begin
          if (lidx >= (CW+1)'(cnt_r)) begin
            state_r <= S_ROOT;
          end else begin
            state_r <= S_DN_RDR;
          end
        end
        S_DN_RDR: begin
          lch_r <= rdata; lok_r <= 1'b1; state_r <= S_DN_CMP;
        end
        S_DN_CMP: begin
          lok_r <= 1'b0;
          if (ridx < (CW+1)'(cnt_r) &&
              rdata < ((cur_r > lch_r) ? lch_r : cur_r)) begin
            idx_r <= AW'(ridx); state_r <= S_DN_RDL;
          end else if (cur_r > lch_r) begin
            idx_r <= AW'(lidx); state_r <= S_DN_RDL;
          end else begin
            state_r <= S_ROOT;
          end
        end
        S_ROOT: state_r <= S_DONE;
        S_DONE: if (res_load) begin
          out_r.status      <= stat_r;
          out_r.removed_key <= KEY_W'(rem_r);
          out_r.entry_count <= CNT_W'(cnt_r);
          out_r.min_key     <= (cnt_r != '0) ? KEY_W'(rdata) : '0;
          out_r.min_valid   <= (cnt_r != '0);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY)) else $error("count beyond capacity");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |=> state_r == S_CHECK) else $error("command not started");
  a_res_fail: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && stat_r != ST_OK |-> rem_r == '0)
    else $error("failed command removed a key");

endmodule : bmh_core
`default_nettype wire

### tb/sv/tb_binary_min_heap_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_min_heap_engine_unit
// Self-checking bench for the min-heap engine: a directed table of commands,
// then random command streams, each result checked against a hand-typed answer or a behavioral heap.
// ----------------------------------------------------------------------------
module tb_binary_min_heap_engine_unit;
  import bmh_pkg::*;

  localparam int CAP = CAPACITY;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_item_t  in_data = '0;
  logic      in_full;
  logic      out_pop = 1'b0;
  out_item_t out_data;
  logic      out_empty;

  binary_min_heap_engine_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_pop(out_pop), .out_data(out_data), .out_empty(out_empty)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // behavioral heap
  logic signed [KEY_W-1:0] heap_keys [CAP];
  int unsigned             heap_size;
  out_item_t               result_fifo [$];
  int                      errors = 0;
  int                      send_idle = 0;
  int                      recv_idle = 0;

  task automatic heap_swap(int unsigned a, int unsigned b);
    logic signed [KEY_W-1:0] t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endtask

  task automatic bubble_up(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(heap_keys[i] < heap_keys[p])) break;
      heap_swap(i, p);
      i = p;
    end
  endtask

  task automatic bubble_down(int unsigned i);
    int unsigned l, r, s;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      s = i;
      if (l < heap_size && heap_keys[i] > heap_keys[l]) s = l;
      if (r < heap_size && heap_keys[r] < heap_keys[s]) s = r;
      if (s == i) break;
      heap_swap(i, s);
      i = s;
    end
  endtask

  task automatic take_out(int unsigned pos, output logic signed [KEY_W-1:0] gone);
    gone = heap_keys[pos];
    heap_size--;
    if (pos < heap_size) begin
      heap_keys[pos] = heap_keys[heap_size];
      if (pos > 0 && heap_keys[pos] < heap_keys[(pos - 1) / 2]) bubble_up(pos);
      else bubble_down(pos);
    end
  endtask

  function automatic out_item_t heap_answer(status_t st, logic signed [KEY_W-1:0] gone);
    out_item_t r;
    r.status      = st;
    r.removed_key = gone;
    r.entry_count = heap_size[CNT_W-1:0];
    r.min_key     = heap_size != 0 ? heap_keys[0] : '0;
    r.min_valid   = heap_size != 0;
    return r;
  endfunction

  // apply one command to the behavioral heap, return its answer
  task automatic run_command(in_item_t c, output out_item_t r);
    status_t                 st;
    logic signed [KEY_W-1:0] gone;
    st = ST_OK;
    gone = '0;
    case (action_t'(c.action))
      ACT_INSERT: begin
        if (heap_size >= CAP) st = ST_FULL;
        else begin
          heap_keys[heap_size] = c.key_value;
          heap_size++;
          bubble_up(heap_size - 1);
        end
      end
      ACT_EXTRACT: begin
        if (heap_size == 0) st = ST_EMPTY;
        else take_out(0, gone);
      end
      ACT_DECR: begin
        if (c.position >= heap_size) st = ST_BADIDX;
        else if (c.key_value > heap_keys[c.position]) st = ST_NOTSMALLER;
        else begin
          heap_keys[c.position] = c.key_value;
          bubble_up(c.position);
        end
      end
      default: begin
        if (heap_size == 0) st = ST_EMPTY;
        else if (c.position >= heap_size) st = ST_BADIDX;
        else take_out(c.position, gone);
      end
    endcase
    r = heap_answer(st, gone);
  endtask

  // send one beat, queue its expected result (typed or predicted)
  task automatic send_beat(in_item_t c, logic typed = 1'b0, out_item_t want = '0);
    out_item_t r;
    while (send_idle > 0 && ($urandom_range(99) < send_idle)) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (in_full) @(posedge clk);
    run_command(c, r);
    if (typed) r = want;
    result_fifo.push_back(r);
  endtask

  function automatic in_item_t make_cmd(action_t a, logic [KEY_W-1:0] k, int unsigned p);
    in_item_t c;
    c.action = a;
    c.key_value = k;
    c.position = p[POS_W-1:0];
    return c;
  endfunction

  // receiver: pop with random stalls, check against oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (result_fifo.size() == 0) begin
        $display("%0t: expected no result, actual %p", $time, out_data);
        errors++;
      end else begin
        if (out_data !== result_fifo[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time, result_fifo[0], out_data);
          errors++;
        end
        void'(result_fifo.pop_front());
      end
    end
    out_pop <= rst_n && !(recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  // directed table: command plus hand-typed answer where it is obvious
  typedef struct {
    in_item_t  cmd;
    logic      typed;
    out_item_t want;
  } row_t;

  localparam logic [KEY_W-1:0] KMIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KMAX = 32'h7fff_ffff;

  initial begin
    row_t      rows [$];
    row_t      rw;
    int        phase, n, act;
    logic [KEY_W-1:0] k;

    rw.typed = 1'b1;
    rw.cmd = make_cmd(ACT_EXTRACT, '0, 0);
    rw.want = '{ST_EMPTY, '0, '0, '0, 1'b0};          rows.push_back(rw);
    rw.cmd = make_cmd(ACT_DELETE, KMAX, 1023);
    rw.want = '{ST_EMPTY, '0, '0, '0, 1'b0};          rows.push_back(rw);
    rw.cmd = make_cmd(ACT_DECR, KMIN, 0);
    rw.want = '{ST_BADIDX, '0, '0, '0, 1'b0};         rows.push_back(rw);
    rw.cmd = make_cmd(ACT_INSERT, KMAX, 1023);
    rw.want = '{ST_OK, '0, 11'd1, KMAX, 1'b1};        rows.push_back(rw);
    rw.cmd = make_cmd(ACT_INSERT, KMIN, 0);
    rw.want = '{ST_OK, '0, 11'd2, KMIN, 1'b1};        rows.push_back(rw);
    rw.cmd = make_cmd(ACT_DECR, KMAX, 1);
    rw.want = '{ST_OK, '0, 11'd2, KMIN, 1'b1};        rows.push_back(rw);
    rw.cmd = make_cmd(ACT_DECR, KMAX, 2);
    rw.want = '{ST_BADIDX, '0, 11'd2, KMIN, 1'b1};    rows.push_back(rw);
    rw.cmd = make_cmd(ACT_DECR, KMAX, 0);
    rw.want = '{ST_NOTSMALLER, '0, 11'd2, KMIN, 1'b1}; rows.push_back(rw);
    rw.cmd = make_cmd(ACT_DELETE, '0, 1023);
    rw.want = '{ST_BADIDX, '0, 11'd2, KMIN, 1'b1};    rows.push_back(rw);
    rw.cmd = make_cmd(ACT_EXTRACT, '0, 0);
    rw.want = '{ST_OK, KMIN, 11'd1, KMAX, 1'b1};      rows.push_back(rw);
    rw.typed = 1'b0;
    for (int i = 0; i < 8; i++) begin
      rw.cmd = make_cmd(ACT_INSERT, 32'(5 - (i % 3)), 0); rows.push_back(rw);
    end
    rw.cmd = make_cmd(ACT_DECR, 32'(-7), 8);    rows.push_back(rw);
    rw.cmd = make_cmd(ACT_DELETE, '1, 3);       rows.push_back(rw);
    rw.cmd = make_cmd(ACT_DELETE, '1, 0);       rows.push_back(rw);
    rw.cmd = make_cmd(ACT_EXTRACT, KMAX, 1023); rows.push_back(rw);
    rw.cmd = make_cmd(ACT_EXTRACT, KMIN, 0);    rows.push_back(rw);

    heap_size = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the table
    foreach (rows[i]) send_beat(rows[i].cmd, rows[i].typed, rows[i].want);
    in_push <= 1'b0;
    while (result_fifo.size() != 0) @(posedge clk);

    // random phases: none / sender idle / receiver stall / both light
    for (phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 1) ? 66 : (phase == 3) ? 8 : 0;
      recv_idle = (phase == 2) ? 66 : (phase == 3) ? 8 : 0;
      for (n = 0; n < 107; n++) begin
        act = $urandom_range(99);
        case ($urandom_range(3))
          0: k = $urandom();
          1: k = $urandom_range(15) - 8;
          2: k = $urandom_range(1) ? KMAX - $urandom_range(3) : KMIN + $urandom_range(3);
          default: k = $urandom_range(200);
        endcase
        if (act < 40 || heap_size < 2)
          send_beat(make_cmd(act < 3 ? action_t'($urandom_range(3)) : ACT_INSERT, k,
                             $urandom_range(1023)));
        else if (act < 60) send_beat(make_cmd(ACT_EXTRACT, k, $urandom_range(1023)));
        else if (act < 80)
          send_beat(make_cmd(ACT_DECR, heap_keys[0] - $urandom_range(4) + 1,
                             $urandom_range(1) ? $urandom_range(heap_size - 1)
                                                : $urandom_range(1023)));
        else
          send_beat(make_cmd(ACT_DELETE, k, $urandom_range(3) != 0 ?
                             $urandom_range(heap_size - 1) : $urandom_range(1023)));
      end
    end
    in_push <= 1'b0;

    while (result_fifo.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && result_fifo.size() == 0) begin
      $display("tb_binary_min_heap_engine_unit: PASS");
    end else begin
      $display("tb_binary_min_heap_engine_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_binary_min_heap_engine_unit: FAIL");
    $finish;
  end

endmodule
